### hw/rtl/dpsg_pkg.sv
// shared types and constants for the dual sound chip register write decoder
package dpsg_pkg;

    localparam int PORT_W    = 8;
    localparam int DATA_W    = 8;
    localparam int PERIOD_W  = 10;
    localparam int VOLUME_W  = 4;
    localparam int HOLD_W    = 3;
    localparam int CHANNEL_W = 2;
    localparam int LREG_W    = 3;
    localparam int NUM_CHIPS = 2;
    localparam int SLOTS     = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    localparam logic [PORT_W-1:0]    PORT_CHIP0    = 8'h01;
    localparam logic [PORT_W-1:0]    PORT_CHIP1    = 8'h02;
    localparam logic [CHANNEL_W-1:0] NOISE_CHANNEL = 2'd3;
    localparam logic [VOLUME_W-1:0]  VOL_SILENT    = 4'hF;
    localparam logic                 KIND_PERIOD   = 1'b0;
    localparam logic                 KIND_VOLUME   = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] write_data;
        logic [PORT_W-1:0] port_address;
    } in_word_t;

    typedef struct packed {
        logic [HOLD_W-1:0]    hold_count;
        logic [VOLUME_W-1:0]  min_volume;
        logic [VOLUME_W-1:0]  volume;
        logic [PERIOD_W-1:0]  period;
        logic [CHANNEL_W-1:0] channel;
        logic                 chip_index;
        logic                 accepted;
    } out_word_t;

endpackage

### hw/rtl/dpsg_in_stage.sv
// input register stage holding one accepted write word
module dpsg_in_stage
    import dpsg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  in_word_t s_word,
    input  logic     advance,
    output logic     in_vld,
    output in_word_t in_word
);

    logic     vld_reg, vld_next;
    in_word_t word_reg, word_next;

    // take a new word when empty or whenever the held one moves on this cycle
    assign s_tready = !vld_reg || advance;

    always_comb begin
        vld_next  = vld_reg;
        word_next = word_reg;
        if (s_tready) begin
            vld_next  = s_tvalid;
            word_next = s_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign in_vld  = vld_reg;
    assign in_word = word_reg;

endmodule

### hw/rtl/dpsg_core.sv
// chip register file, latch/data decode and result register
module dpsg_core
    import dpsg_pkg::*;
#(
    parameter int HOLD_RELOAD = 6
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_vld,
    input  in_word_t  in_word,
    output logic      advance,
    output logic      m_tvalid,
    input  logic      m_tready,
    output out_word_t m_word
);

    logic [LREG_W-1:0]   lreg_reg [NUM_CHIPS];
    logic [PERIOD_W-1:0] period_reg [SLOTS];
    logic [VOLUME_W-1:0] volume_reg [SLOTS];
    logic [VOLUME_W-1:0] minvol_reg [SLOTS];
    logic [HOLD_W-1:0]   hold_reg [SLOTS];

    logic      out_vld_reg, out_vld_next;
    out_word_t res_reg, res_next;

    logic                 hit, chip, is_latch, kind;
    logic [DATA_W-1:0]    data;
    logic [LREG_W-1:0]    lr_cur, lr_new;
    logic [CHANNEL_W-1:0] ch;
    logic [2:0]           slot;
    logic [PERIOD_W-1:0]  per_cur, per_new;
    logic [VOLUME_W-1:0]  vol_cur, vol_new, min_cur, min_new;
    logic [HOLD_W-1:0]    hold_cur, hold_new;
    logic                 wr_en;

    assign advance = in_vld && (!out_vld_reg || m_tready);

    always_comb begin
        data     = in_word.write_data;
        hit      = (in_word.port_address == PORT_CHIP0) ||
                   (in_word.port_address == PORT_CHIP1);
        chip     = (in_word.port_address == PORT_CHIP1);
        is_latch = data[7];
        kind     = data[4];
        lr_cur   = lreg_reg[chip];
        lr_new   = is_latch ? {data[6:5], kind} : lr_cur;
        ch       = lr_new[LREG_W-1:1];
        slot     = {chip, ch};
        per_cur  = period_reg[slot];
        vol_cur  = volume_reg[slot];
        min_cur  = minvol_reg[slot];
        hold_cur = hold_reg[slot];
        per_new  = per_cur;
        vol_new  = vol_cur;
        min_new  = min_cur;
        hold_new = hold_cur;
        if (is_latch) begin
            if (kind == KIND_PERIOD) begin
                per_new = {per_cur[PERIOD_W-1:4], data[3:0]};
            end else begin
                vol_new = data[3:0];
                if (vol_new < min_cur) begin
                    min_new = vol_new;
                end
                if (vol_new != VOL_SILENT) begin
                    hold_new = HOLD_W'(HOLD_RELOAD);
                end
            end
        end else if (lr_cur[0] == KIND_PERIOD) begin
            // noise channel keeps only three bits, upper bits cleared
            if (ch == NOISE_CHANNEL) begin
                per_new = {7'd0, data[2:0]};
            end else begin
                per_new = {data[5:0], per_cur[3:0]};
            end
        end
        wr_en = advance && hit;
    end

    always_comb begin
        res_next = '0;
        if (hit) begin
            res_next.accepted   = 1'b1;
            res_next.chip_index = chip;
            res_next.channel    = ch;
            res_next.period     = per_new;
            res_next.volume     = vol_new;
            res_next.min_volume = min_new;
            res_next.hold_count = hold_new;
        end
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
            for (int i = 0; i < NUM_CHIPS; i++) begin
                lreg_reg[i] <= '0;
            end
            for (int i = 0; i < SLOTS; i++) begin
                period_reg[i] <= '0;
                volume_reg[i] <= '0;
                minvol_reg[i] <= VOL_SILENT;
                hold_reg[i]   <= '0;
            end
        end else begin
            out_vld_reg <= out_vld_next;
            if (wr_en) begin
                lreg_reg[chip]   <= lr_new;
                period_reg[slot] <= per_new;
                volume_reg[slot] <= vol_new;
                minvol_reg[slot] <= min_new;
                hold_reg[slot]   <= hold_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_word   = res_reg;

    a_adv_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_vld_reg)
        else $error("advanced word did not reach the result register");

    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !res_reg.accepted) |-> (res_reg == '0))
        else $error("ignored port produced nonzero result");

    a_latch_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && hit && is_latch) |=> (res_reg.channel == $past(data[6:5])))
        else $error("latch did not select the written channel");

    a_vol_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && hit && is_latch && kind == KIND_VOLUME) |=>
            (res_reg.min_volume <= res_reg.volume))
        else $error("minimum volume above new volume");

endmodule

### hw/rtl/dual_psg_register_write_decoder.sv
// top level of the dual sound chip register write decoder
//
// channel | dir | word contents (lsb first)
// s_*     | in  | port_address[7:0], write_data[15:8]
// m_*     | out | accepted, chip_index, channel, period, volume, min_volume, hold_count
//
// one word per cycle sustained while m_tready is high; an accepted word passes through the
// input register, then the decode into the result register, before it is on m_tdata
// per-chip state updates in the same edge the result loads, so back-to-back
// words see each other's writes
// synchronous active-low reset clears latch indexes, periods, volumes and holds,
// and sets minimum volumes to silent
// m_tready low stalls the result; the input register still takes one more word if it is empty
module dual_psg_register_write_decoder
    import dpsg_pkg::*;
#(
    parameter int HOLD_RELOAD = 6
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [7:0] port_address, [15:8] write_data
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] accepted, [1] chip_index, [3:2] channel, [13:4] period,
    // [17:14] volume, [21:18] min_volume, [24:22] hold_count, rest zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    in_word_t  s_word, in_word;
    out_word_t m_word;
    logic      in_vld, advance;

    assign s_word = in_word_t'(s_tdata);

    dpsg_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_word   (s_word),
        .advance  (advance),
        .in_vld   (in_vld),
        .in_word  (in_word)
    );

    dpsg_core #(
        .HOLD_RELOAD (HOLD_RELOAD)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_vld   (in_vld),
        .in_word  (in_word),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_word   (m_word)
    );

    assign m_tdata = {{(OUT_TDATA_W - $bits(out_word_t)){1'b0}}, m_word};

endmodule
